// ===== src/swmc_pkg.sv =====
// Package for the sliding-window median cost unit.
// Holds shared constants and the cell control word; no dependencies.
`timescale 1ns / 1ps
package swmc_pkg;
	localparam int WINDOW_MAX_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 32;
	localparam int CFG_BITS        = 7;
	localparam int MEDIAN_BITS     = 32;
	localparam int COST_BITS       = 38;

	// control word broadcast to every cell of the sorted chain
	typedef struct packed {
		logic clr;    // drop every entry
		logic del;    // remove one copy of the key
		logic ins;    // insert the key in order
		logic load;   // copy values into the scan lane
		logic shift;  // advance the scan lane toward cell 0
	} cell_ctrl_t;
endpackage

// ===== src/swmc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module swmc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== src/swmc_cell.sv =====
// One cell of the sorted chain: holds one window value plus a scan lane.
// Depends on swmc_pkg.
`timescale 1ns / 1ps
module swmc_cell #(
	parameter int  SAMPLE_BITS = swmc_pkg::SAMPLE_BITS_DEF,
	parameter bit  FIRST       = 1'b0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  swmc_pkg::cell_ctrl_t   ctrl,
	input  logic [SAMPLE_BITS-1:0] key,
	input  logic [SAMPLE_BITS-1:0] prv_val,
	input  logic                   prv_vld,
	input  logic [SAMPLE_BITS-1:0] nxt_val,
	input  logic                   nxt_vld,
	input  logic [SAMPLE_BITS-1:0] nxt_scan,
	output logic [SAMPLE_BITS-1:0] val_q,
	output logic                   vld_q,
	output logic [SAMPLE_BITS-1:0] scan_q
);
	logic take_nxt;
	logic keep;
	logic take_key;

	// entries at or above the key close the gap left by the deleted copy
	assign take_nxt = vld_q && (val_q >= key);
	assign keep     = vld_q && (val_q <= key);
	assign take_key = FIRST || (prv_vld && (prv_val <= key));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctrl.clr) begin
			vld_q <= 1'b0;
		end else if (ctrl.del) begin
			if (take_nxt) vld_q <= nxt_vld;
		end else if (ctrl.ins) begin
			if (!keep) vld_q <= take_key ? 1'b1 : prv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.del) begin
			if (take_nxt) val_q <= nxt_val;
		end else if (ctrl.ins) begin
			if (!keep) val_q <= take_key ? key : prv_val;
		end
		if (ctrl.load) begin
			scan_q <= val_q;
		end else if (ctrl.shift) begin
			scan_q <= nxt_scan;
		end
	end
endmodule

// ===== src/sliding_window_median_cost_unit.sv =====
// Sliding-window median and absolute-deviation cost, top level.
// Depends on swmc_pkg, swmc_ram and swmc_cell.
`timescale 1ns / 1ps
// Each accepted sample word enters a window of the last window_size samples
// (1..WINDOW_MAX; 0 acts as 1, larger values as WINDOW_MAX). The window is
// kept sorted in a chain of WINDOW_MAX cells: once it is full, state S_DEL
// removes the oldest sample (read from a history RAM), then S_INS inserts
// the new one in order. Once the window is full every sample gives one
// result word: the lower median and the sum of |x - median| over the
// window. The sum is built by shifting the sorted values through a scan
// lane into one accumulator, one value a cycle; while the window is still
// filling an item gives no result. Results wait in an output register; a
// sample is taken only when the unit is back in idle.
// Writing window_size empties the window and starts filling again.
module sliding_window_median_cost_unit #(
	parameter int WINDOW_MAX  = swmc_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = swmc_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [swmc_pkg::CFG_BITS-1:0] cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [SAMPLE_BITS-1:0]        sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [swmc_pkg::MEDIAN_BITS-1:0] median,
	output logic [swmc_pkg::COST_BITS-1:0]   cost
);
	localparam int CW = $clog2(WINDOW_MAX + 1);
	localparam int PW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_DEL  = 6'b000010,
		S_INS  = 6'b000100,
		S_MED  = 6'b001000,
		S_SUM  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t                       state_q;
	logic [CW-1:0]                win_q;
	logic [CW-1:0]                fill_q;
	logic [PW-1:0]                ptr_q;
	logic [CW-1:0]                cnt_q;
	logic                         was_full_q;
	logic                         now_full_q;
	logic [SAMPLE_BITS-1:0]       smp_q;
	logic [SAMPLE_BITS-1:0]       md_q;
	logic [swmc_pkg::COST_BITS-1:0] acc_q;
	logic                         out_valid_q;
	logic [swmc_pkg::MEDIAN_BITS-1:0] median_q;
	logic [swmc_pkg::COST_BITS-1:0]   cost_q;

	logic                         in_acc;
	logic [SAMPLE_BITS-1:0]       old_val;
	logic [CW-1:0]                cfg_win;
	logic [CW-1:0]                ptr_inc;
	logic [CW-1:0]                fill_nxt;
	logic [CW-1:0]                med_idx;
	logic [SAMPLE_BITS-1:0]       diff;
	logic                         out_load;
	swmc_pkg::cell_ctrl_t         ctrl;
	logic [SAMPLE_BITS-1:0]       key;

	logic [SAMPLE_BITS-1:0] val_w  [WINDOW_MAX];
	logic                   vld_w  [WINDOW_MAX];
	logic [SAMPLE_BITS-1:0] scan_w [WINDOW_MAX];

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;

	// clamp the written size into 1..WINDOW_MAX
	always_comb begin
		if (cfg_wdata == '0) begin
			cfg_win = CW'(1);
		end else if (int'(cfg_wdata) > WINDOW_MAX) begin
			cfg_win = CW'(WINDOW_MAX);
		end else begin
			cfg_win = CW'(cfg_wdata);
		end
	end

	assign ptr_inc  = CW'(ptr_q) + CW'(1);
	assign fill_nxt = (fill_q < win_q) ? fill_q + CW'(1) : fill_q;
	assign med_idx  = (win_q - CW'(1)) >> 1;
	assign diff     = (scan_w[0] >= md_q) ? scan_w[0] - md_q : md_q - scan_w[0];
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// history of raw samples; read the oldest while writing the newest
	swmc_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(WINDOW_MAX),
		.AW   (PW)
	) u_ring (
		.clk  (clk),
		.we   (in_acc),
		.waddr(ptr_q),
		.wdata(sample),
		.raddr(ptr_q),
		.rdata(old_val)
	);

	always_comb begin
		ctrl.clr   = cfg_we;
		ctrl.del   = (state_q == S_DEL) && was_full_q;
		ctrl.ins   = (state_q == S_INS);
		ctrl.load  = (state_q == S_MED);
		ctrl.shift = (state_q == S_SUM);
		key        = (state_q == S_DEL) ? old_val : smp_q;
	end

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		logic [SAMPLE_BITS-1:0] pv;
		logic                   pl;
		logic [SAMPLE_BITS-1:0] nv;
		logic                   nl;
		logic [SAMPLE_BITS-1:0] ns;
		if (i == 0) begin : g_lo
			assign pv = '0;
			assign pl = 1'b0;
		end else begin : g_mid
			assign pv = val_w[i-1];
			assign pl = vld_w[i-1];
		end
		if (i == WINDOW_MAX - 1) begin : g_hi
			assign nv = '0;
			assign nl = 1'b0;
			assign ns = '0;
		end else begin : g_up
			assign nv = val_w[i+1];
			assign nl = vld_w[i+1];
			assign ns = scan_w[i+1];
		end
		swmc_cell #(
			.SAMPLE_BITS(SAMPLE_BITS),
			.FIRST      (i == 0)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.key     (key),
			.prv_val (pv),
			.prv_vld (pl),
			.nxt_val (nv),
			.nxt_vld (nl),
			.nxt_scan(ns),
			.val_q   (val_w[i]),
			.vld_q   (vld_w[i]),
			.scan_q  (scan_w[i])
		);
	end

	// control: size, fill, ring pointer, sequencer, output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			win_q       <= CW'(1);
			fill_q      <= '0;
			ptr_q       <= '0;
			cnt_q       <= '0;
			was_full_q  <= 1'b0;
			now_full_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// hold the word until taken, load a new one from done
			out_valid_q <= out_load || (out_valid_q && !out_ready);
			if (cfg_we) begin
				win_q  <= cfg_win;
				fill_q <= '0;
				ptr_q  <= '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						// advance the ring and count the fill
						ptr_q      <= (ptr_inc >= win_q) ? '0 : ptr_q + PW'(1);
						fill_q     <= fill_nxt;
						was_full_q <= (fill_q >= win_q);
						now_full_q <= (fill_nxt >= win_q);
						state_q    <= S_DEL;
					end
				end
				S_DEL: state_q <= S_INS;
				S_INS: state_q <= now_full_q ? S_MED : S_IDLE;
				S_MED: begin
					cnt_q   <= win_q;
					state_q <= S_SUM;
				end
				S_SUM: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers: hold the sample, pick the median, accumulate
	always_ff @(posedge clk) begin
		if (in_acc) smp_q <= sample;
		if (state_q == S_MED) begin
			md_q  <= val_w[med_idx[PW-1:0]];
			acc_q <= '0;
		end
		if (state_q == S_SUM) begin
			acc_q <= acc_q + swmc_pkg::COST_BITS'(diff);
		end
		if (out_load) begin
			median_q <= swmc_pkg::MEDIAN_BITS'(md_q);
			cost_q   <= acc_q;
		end
	end

	assign out_valid = out_valid_q;
	assign median    = median_q;
	assign cost      = cost_q;

	// samples only enter while idle
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> state_q == S_IDLE)
		else $error("sample taken outside idle");

	// fill never passes the window size
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= win_q)
		else $error("fill count above window size");

	// the scan runs at most one pass over the window
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SUM |-> (cnt_q != '0 && cnt_q <= win_q))
		else $error("scan count out of range");

	// a result is only loaded once the window is full
	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MED |-> now_full_q)
		else $error("result without a full window");
endmodule

// ===== test/tb_top.sv =====
// Testbench for the sliding-window median cost unit.
// Drives sample words against a local window predictor; depends on swmc_pkg and the RTL.
`timescale 1ns / 1ps
module tb_top;
	localparam int WMAX      = swmc_pkg::WINDOW_MAX_DEF;
	localparam int CYC_LIMIT = 900000;
	localparam int N_RAND    = 1150;

	typedef struct packed {
		logic [swmc_pkg::MEDIAN_BITS-1:0] med;
		logic [swmc_pkg::COST_BITS-1:0]   cst;
	} med_cost_t;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_we;
	logic [swmc_pkg::CFG_BITS-1:0]    cfg_wdata;
	logic                             in_valid;
	logic                             in_ready;
	logic [31:0]                      sample;
	logic                             out_valid;
	logic                             out_ready;
	logic [swmc_pkg::MEDIAN_BITS-1:0] median;
	logic [swmc_pkg::COST_BITS-1:0]   cost;

	// predictor state: window size, fill level, ring of held samples
	int unsigned     win_len;
	int unsigned     fill_lvl;
	int unsigned     ring_wr;
	logic [31:0]     ring_q [WMAX];
	med_cost_t       pending_q [$];

	int unsigned     cycle_cnt;
	int unsigned     mismatch_cnt;
	int unsigned     result_cnt;
	int unsigned     sent_cnt;
	bit              quiet_tail;

	sliding_window_median_cost_unit DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .sample(sample),
		.out_valid(out_valid), .out_ready(out_ready), .median(median), .cost(cost)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop on a hung run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYC_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("[sliding_window_median_cost_unit] ERROR");
			$finish;
		end
	end

	// Push one sample into the predicted window; queue a result when full.
	function automatic void predict_window(logic [31:0] s);
		logic [31:0] srt [WMAX];
		logic [31:0] v, md;
		logic [swmc_pkg::COST_BITS-1:0] acc;
		int j;
		med_cost_t r;
		ring_q[ring_wr] = s;
		ring_wr = (ring_wr + 1 >= win_len) ? 0 : ring_wr + 1;
		if (fill_lvl < win_len) fill_lvl++;
		if (fill_lvl < win_len) return;
		for (int i = 0; i < win_len; i++) begin
			v = ring_q[i];
			j = i;
			while (j > 0 && srt[j-1] > v) begin
				srt[j] = srt[j-1];
				j--;
			end
			srt[j] = v;
		end
		md = srt[(win_len - 1) / 2];
		acc = '0;
		for (int i = 0; i < win_len; i++)
			acc += (srt[i] >= md) ? swmc_pkg::COST_BITS'(srt[i] - md)
				: swmc_pkg::COST_BITS'(md - srt[i]);
		r.med = md;
		r.cst = acc;
		pending_q = {pending_q, r};
	endfunction

	// Random stall on the result side; none in the quiet tail.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet_tail && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Compare every accepted result word with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			result_cnt <= result_cnt + 1;
			if (pending_q.size() == 0) begin
				mismatch_cnt = mismatch_cnt + 1;
				if (mismatch_cnt <= 10)
					$display("unexpected result med=%h cost=%h", median, cost);
			end else begin
				med_cost_t e;
				e = pending_q.pop_front();
				if (e.med !== median || e.cst !== cost) begin
					mismatch_cnt = mismatch_cnt + 1;
					if (mismatch_cnt <= 10)
						$display("mismatch: exp med=%h cost=%h got med=%h cost=%h",
							e.med, e.cst, median, cost);
				end
			end
		end
	end

	// Send one sample word; hold valid and payload until accepted.
	task automatic send_sample(logic [31:0] s);
		if (!quiet_tail && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		do @(posedge clk); while (!in_ready);
		predict_window(s);
		sent_cnt++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		// filling items give no result; wait out their processing plus margin
		repeat (WMAX + 10) @(posedge clk);
	endtask

	// Drain all results, let the block settle, then write window_size.
	task automatic set_window(logic [swmc_pkg::CFG_BITS-1:0] w);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_we   <= 1'b0;
		win_len  = (w == 0) ? 1 : (w > WMAX) ? WMAX : w;
		fill_lvl = 0;
		ring_wr  = 0;
	endtask

	function automatic logic [31:0] rand_sample(int mode);
		case (mode)
			0: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			1: return $urandom_range(0, 3);
			2: return 32'h8000_0000 + $urandom_range(0, 7);
			default: return $urandom;
		endcase
	endfunction

	// Reset default window of one: every sample returns itself, cost zero.
	task automatic test_default_window();
		send_sample(32'h0);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'h1234_5678);
	endtask

	// Extremes: largest window full of max and zero values, and even/odd sizes.
	task automatic test_directed_extremes();
		set_window(7'd3);
		send_sample(32'hFFFF_FFFF); send_sample(32'h0); send_sample(32'hFFFF_FFFF);
		send_sample(32'h0);
		set_window(7'd2);
		send_sample(32'h5); send_sample(32'h9); send_sample(32'h9);
		set_window(7'd0);      // zero acts as one
		send_sample(32'hA5A5_A5A5); send_sample(32'h5A5A_5A5A);
		set_window(7'd127);    // above the maximum clamps
		for (int i = 0; i < WMAX + 2; i++)
			send_sample((i % 2) ? 32'hFFFF_FFFF : 32'h0);
	endtask

	// Restart filling mid-window, then random-size phases.
	task automatic test_random_phases();
		int n;
		int mode;
		logic [swmc_pkg::CFG_BITS-1:0] w;
		set_window(7'd5);
		send_sample(32'h1); send_sample(32'h2);
		set_window(7'd4);      // restart before full
		while (sent_cnt < N_RAND) begin
			case ($urandom_range(0, 5))
				0: w = 7'd64;
				1: w = 7'd1;
				2: w = 7'($urandom_range(65, 127));
				default: w = 7'($urandom_range(1, 12));
			endcase
			set_window(w);
			mode = $urandom_range(0, 4);
			n = $urandom_range(win_len + 1, win_len + 30);
			if (sent_cnt > N_RAND * 3 / 4) quiet_tail = 1'b1;
			for (int i = 0; i < n; i++)
				send_sample(rand_sample(mode));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_wdata = '0; in_valid = 1'b0; sample = '0;
		cycle_cnt = 0; mismatch_cnt = 0; result_cnt = 0; sent_cnt = 0;
		quiet_tail = 1'b0;
		win_len = 1; fill_lvl = 0; ring_wr = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_window();
		test_directed_extremes();
		test_random_phases();
		drain_results();
		$display("sent %0d samples, checked %0d results over many window sizes",
			sent_cnt, result_cnt);
		if (mismatch_cnt == 0 && pending_q.size() == 0)
			$display("[sliding_window_median_cost_unit] OK");
		else
			$display("[sliding_window_median_cost_unit] ERROR");
		$finish;
	end
endmodule
